// ===== rtl/core/smlc_pkg.sv =====
// Shared constants and types for the streaming substring matcher.
// Used by smlc_matcher and substring_match_line_column; depends on nothing.
package smlc_pkg;

    localparam int MAX_NEEDLE_DEF = 16;
    localparam int NEEDLE_CAP     = 16;
    localparam int CHAR_W         = 8;
    localparam int NEEDLE_W       = NEEDLE_CAP * CHAR_W;
    localparam int LEN_W          = 5;
    localparam int COUNT_W        = 24;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_INDEX_W    = 2;

    localparam logic [CHAR_W-1:0]      NEWLINE   = 8'h0A;
    localparam logic [COUNT_W-1:0]     COUNT_MAX = '1;

    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_LOW    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_HIGH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_LENGTH = 2'd2;

    typedef struct packed {
        logic               advance;
        logic               clear;
        logic [CHAR_W-1:0]  ch;
        logic [LEN_W-1:0]   len;
        logic [COUNT_W-1:0] line;
        logic [COUNT_W-1:0] column;
    } step_t;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] line;
        logic [COUNT_W-1:0] column;
    } match_t;

endpackage

// ===== rtl/core/smlc_matcher.sv =====
// Shift-and prefix vector and per-prefix start positions.
// Depends on smlc_pkg for step_t, match_t and widths.
module smlc_matcher #(
    parameter int LANES = smlc_pkg::NEEDLE_CAP
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  smlc_pkg::step_t               step,
    input  logic [smlc_pkg::NEEDLE_W-1:0] needle,
    output smlc_pkg::match_t              match
);

    localparam int POS_W = 2 * smlc_pkg::COUNT_W;

    logic [LANES-1:0] active_reg;
    logic [LANES-1:0] active_next;
    logic [LANES-1:0] active_eff;
    logic [LANES-1:0] prev_vec;
    logic [LANES-1:0] hit;
    logic [POS_W-1:0] hist_reg [LANES];
    logic [POS_W-1:0] src [LANES];
    logic [POS_W-1:0] start;
    logic             found;

    always_comb
    begin
        active_eff = step.clear ? '0 : active_reg;
        prev_vec   = LANES'({active_eff, 1'b1});
        src[0]     = {step.line, step.column};
        for (int i = 1; i < LANES; i++)
        begin
            src[i] = hist_reg[i-1];
        end
        found = 1'b0;
        start = '0;
        for (int i = 0; i < LANES; i++)
        begin
            hit[i] = (smlc_pkg::LEN_W'(i) < step.len) && prev_vec[i]
                     && (step.ch == needle[smlc_pkg::CHAR_W*i +: smlc_pkg::CHAR_W]);
            active_next[i] = hit[i] && (step.len != smlc_pkg::LEN_W'(i + 1));
            if (step.len == smlc_pkg::LEN_W'(i + 1))
            begin
                found = hit[i];
                start = src[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else if (step.advance)
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.advance)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if (hit[i])
                begin
                    hist_reg[i] <= src[i];
                end
            end
        end
    end

    assign match.found  = found;
    assign match.line   = start[POS_W-1:smlc_pkg::COUNT_W];
    assign match.column = start[smlc_pkg::COUNT_W-1:0];

    assert property (@(posedge clk) disable iff (!rst_n)
        step.advance |=> !active_reg[LANES-1])
        else $error("full-length prefix bit kept after a match");

    assert property (@(posedge clk) disable iff (!rst_n)
        step.advance |=> ((active_reg >> $past(step.len)) == '0))
        else $error("prefix bit set at or above needle length");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step.advance && match.found) |-> (step.len != '0))
        else $error("match reported for empty needle");

endmodule

// ===== rtl/core/substring_match_line_column.sv =====
// Top level of the streaming substring matcher with line and column tracking.
// Depends on smlc_pkg and smlc_matcher.
//
// Takes one text character per cycle while in_stall is low and reports, for each
// completed occurrence of the configured needle (up to 16 bytes), the line and
// column where it began. A 0x0A character starts a new line and itself sits at
// column 0; counters start at line 1, column 0 and saturate. Each accepted item's
// result, if any, appears in the output register on the next cycle; the sustained
// rate is one item per cycle unless in_stall holds the input, as the prefix bit
// vector is updated with each accepted item. An empty needle yields a result at
// every character. Write the needle registers only while no item is in flight.
module substring_match_line_column #(
    parameter int MAX_NEEDLE = smlc_pkg::MAX_NEEDLE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [smlc_pkg::CHAR_W-1:0]      text_char,
    input  logic                             restart,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [smlc_pkg::COUNT_W-1:0]     match_line,
    output logic [smlc_pkg::COUNT_W-1:0]     match_column,
    input  logic                             cfg_write,
    input  logic [smlc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [smlc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int LANES = (MAX_NEEDLE < smlc_pkg::NEEDLE_CAP) ? MAX_NEEDLE
                                                               : smlc_pkg::NEEDLE_CAP;

    logic [smlc_pkg::CFG_DATA_W-1:0] needle_low_reg;
    logic [smlc_pkg::CFG_DATA_W-1:0] needle_high_reg;
    logic [smlc_pkg::LEN_W-1:0]      needle_length_reg;
    logic [smlc_pkg::LEN_W-1:0]      len_eff;

    logic [smlc_pkg::COUNT_W-1:0] line_reg;
    logic [smlc_pkg::COUNT_W-1:0] line_next;
    logic [smlc_pkg::COUNT_W-1:0] col_reg;
    logic [smlc_pkg::COUNT_W-1:0] col_next;
    logic [smlc_pkg::COUNT_W-1:0] line_cur;
    logic [smlc_pkg::COUNT_W-1:0] col_cur;

    logic                         out_valid_reg;
    logic [smlc_pkg::COUNT_W-1:0] match_line_reg;
    logic [smlc_pkg::COUNT_W-1:0] match_column_reg;

    logic             accept;
    logic             has_result;
    smlc_pkg::step_t  step;
    smlc_pkg::match_t match;

    function automatic logic [smlc_pkg::COUNT_W-1:0] sat_inc(
        input logic [smlc_pkg::COUNT_W-1:0] v
    );
        return (v == smlc_pkg::COUNT_MAX) ? v : v + smlc_pkg::COUNT_W'(1);
    endfunction

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign len_eff  = (needle_length_reg > smlc_pkg::LEN_W'(LANES))
                      ? smlc_pkg::LEN_W'(LANES) : needle_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_low_reg    <= '0;
            needle_high_reg   <= '0;
            needle_length_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                smlc_pkg::CFG_NEEDLE_LOW:    needle_low_reg    <= cfg_data;
                smlc_pkg::CFG_NEEDLE_HIGH:   needle_high_reg   <= cfg_data;
                smlc_pkg::CFG_NEEDLE_LENGTH: needle_length_reg <= cfg_data[smlc_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // restart clears the counters before this character; a newline then advances the line
    always_comb
    begin
        line_cur = restart ? smlc_pkg::COUNT_W'(1) : line_reg;
        col_cur  = restart ? '0 : col_reg;
        if (text_char == smlc_pkg::NEWLINE)
        begin
            line_cur = sat_inc(line_cur);
            col_cur  = '0;
        end
        line_next = line_cur;
        col_next  = sat_inc(col_cur);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= smlc_pkg::COUNT_W'(1);
            col_reg  <= '0;
        end
        else if (accept)
        begin
            line_reg <= line_next;
            col_reg  <= col_next;
        end
    end

    assign step.advance = accept;
    assign step.clear   = restart;
    assign step.ch      = text_char;
    assign step.len     = len_eff;
    assign step.line    = line_cur;
    assign step.column  = col_cur;

    smlc_matcher #(
        .LANES (LANES)
    ) u_matcher (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .needle ({needle_high_reg, needle_low_reg}),
        .match  (match)
    );

    assign has_result = (len_eff == '0) || match.found;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= has_result;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && has_result)
        begin
            match_line_reg   <= match.found ? match.line : line_cur;
            match_column_reg <= match.found ? match.column : col_cur;
        end
    end

    assign out_valid    = out_valid_reg;
    assign match_line   = match_line_reg;
    assign match_column = match_column_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0)
        else $error("line counter reached zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (len_eff == '0)) |=> out_valid)
        else $error("empty needle item gave no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && restart && (text_char != smlc_pkg::NEWLINE))
        |=> ((line_reg == smlc_pkg::COUNT_W'(1)) && (col_reg == smlc_pkg::COUNT_W'(1))))
        else $error("restart did not reset the position counters");

endmodule
